[rtl/infix_expression_evaluator_macros.svh]
// assertion macros for the infix expression evaluator
`ifndef INFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define INFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`ifndef SYNTH
`define IEE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define IEE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define IEE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define IEE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/iee_pkg.sv]
// shared types, constants and helpers of the infix expression evaluator
`timescale 1ns / 1ps
package iee_pkg;

   localparam int STACK_DEPTH     = 32;
   localparam int FRAC_BITS       = 32;
   localparam int MAX_FRAC_DIGITS = 9;

   localparam int IDX_W = $clog2(STACK_DEPTH);
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   function automatic longint unsigned pow10(input int n);
      longint unsigned p;
      p = 1;
      for (int k = 0; k < n; k++) p = p * 10;
      return p;
   endfunction

   localparam int FR_W   = $clog2(pow10(MAX_FRAC_DIGITS) + 1);
   localparam int FDC_W  = $clog2(MAX_FRAC_DIGITS + 1);
   localparam int FCNT_W = $clog2(FRAC_BITS);

   localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;
   localparam logic [63:0] INT_MAX = (64'd1 << (63 - FRAC_BITS)) - 64'd1;

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;

   typedef enum logic [2:0] {
      OPC_NONE = 3'd0,
      OPC_ADD  = 3'd1,
      OPC_SUB  = 3'd2,
      OPC_MUL  = 3'd3,
      OPC_DIV  = 3'd4,
      OPC_LPAR = 3'd5
   } opc_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_INVALID_CHAR = 3'd1,
      ST_PARENS       = 3'd2,
      ST_INVALID_EXPR = 3'd3,
      ST_DIV_ZERO     = 3'd4,
      ST_STACK_FULL   = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_FIN,
      S_CHAR,
      S_RPAR,
      S_OPLOOP,
      S_FLUSH,
      S_AP_B,
      S_AP_A,
      S_EXEC,
      S_WAIT,
      S_RESULT
   } state_type;

   typedef struct packed {
      logic load_item;
      logic do_digit;
      logic do_dot;
      logic fin_start;
      logic push_lpar;
      logic push_cur;
      logic pop_op;
      logic pop_discard;
      logic set_perr_char;
      logic set_perr_paren;
      logic set_eval_expr;
      logic take_b;
      logic take_a;
      logic exec_start;
      logic final_check;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic is_end;
      logic halted;
      logic is_digit;
      logic is_dot;
      logic is_ws;
      logic is_lpar;
      logic is_rpar;
      logic is_opchar;
      logic phase_active;
      logic op_empty;
      logic top_is_lpar;
      logic prio_ge;
      logic val_lt2;
      logic exec_long;
      logic md_done;
      logic fin_done;
      logic out_busy;
   } sts_type;

   function automatic logic [1:0] prio(input opc_type op);
      logic [1:0] p;
      p = 2'd0;
      if (op == OPC_ADD || op == OPC_SUB) p = 2'd1;
      if (op == OPC_MUL || op == OPC_DIV) p = 2'd2;
      return p;
   endfunction

endpackage

[rtl/infix_expression_evaluator.sv]
// Streaming infix expression evaluator.
// Input channel (req_): one ASCII character per transfer, or an end marker
// that closes the expression. Result channel (rsp_): one transfer per end
// marker carrying a signed Q32.32 value, a status code and an overflow flag.
// The input stalls while an item is worked on. A digit, or a dot inside a
// number, is captured and then decoded; whitespace, '(' and an invalid
// character then pass the character step, ')' and an operator after that
// unwind the operators they apply. Closing a number adds a 32-step fraction
// conversion. Every operator that leaves the operator stack takes operand b,
// then a, then executes: add, subtract or a divide by zero directly, a multiply
// by shift-add (one bit a cycle), a divide by restoring division (one quotient
// bit a cycle); one that finds too few operands is dropped. Once the last
// operator is applied and the stack is empty, the result step loads the
// result register, which drives rsp_valid, when no earlier result is waiting.
// The result register holds while rsp_stall is high; the next expression is
// taken in meanwhile, and only a second result waits for the first transfer.
// Synchronous reset empties both stacks, clears all flags and drops rsp_valid.
// After each result the block returns to that same empty state.
`timescale 1ns / 1ps
`include "infix_expression_evaluator_macros.svh"
module infix_expression_evaluator (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_character,
   input  logic               req_end_marker,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [63:0] rsp_value,
   output logic [2:0]         rsp_status,
   output logic               rsp_overflow
);
   import iee_pkg::*;

   cmd_type cmd_w;
   sts_type sts_w;

   iee_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts_w),
      .cmd       (cmd_w)
   );

   iee_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd_w),
      .sts            (sts_w),
      .req_character  (req_character),
      .req_end_marker (req_end_marker),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_value      (rsp_value),
      .rsp_status     (rsp_status),
      .rsp_overflow   (rsp_overflow)
   );

   `IEE_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "input not stalled after transfer")
   `IEE_ASSERT_NXT(a_emit_shows, clock, reset, cmd_w.emit, rsp_valid, "result not presented after emit")
   `IEE_ASSERT_IMP(a_err_zero_value, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_value == 64'sd0, "nonzero value with error status")

endmodule

[rtl/iee_muldiv.sv]
// iterative saturating fixed point multiply and divide unit
`timescale 1ns / 1ps
module iee_muldiv (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        is_div,
   input  logic [63:0] opa,
   input  logic [63:0] opb,
   output logic        done,
   output logic [63:0] result,
   output logic        ovf
);
   import iee_pkg::*;

   logic         busy_ff, busy_in;
   logic         fin_ff, fin_in;
   logic         div_ff, div_in;
   logic         neg_ff, neg_in;
   logic         big_ff, big_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [63:0]  y_ff, y_in;
   logic [63:0]  hi_ff, hi_in;
   logic [63:0]  lo_ff, lo_in;
   logic [127:0] n_ff, n_in;

   logic [63:0]  mag_a, mag_b;
   logic [64:0]  msum, r2, rdiff;
   logic         ge, last;
   logic [127:0] prod;
   logic [63:0]  mag;
   logic         big;

   always_comb begin
      mag_a = opa[63] ? (64'd0 - opa) : opa;
      mag_b = opb[63] ? (64'd0 - opb) : opb;
      msum  = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, y_ff} : 65'd0);
      r2    = {hi_ff, n_ff[127]};
      rdiff = r2 - {1'b0, y_ff};
      ge    = r2 >= {1'b0, y_ff};
      last  = div_ff ? (cnt_ff == 7'd127) : (cnt_ff == 7'd63);

      busy_in = busy_ff;
      fin_in  = 1'b0;
      div_in  = div_ff;
      neg_in  = neg_ff;
      big_in  = big_ff;
      cnt_in  = cnt_ff;
      y_in    = y_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      n_in    = n_ff;
      if (start) begin
         busy_in = 1'b1;
         div_in  = is_div;
         neg_in  = opa[63] ^ opb[63];
         big_in  = 1'b0;
         cnt_in  = 7'd0;
         y_in    = mag_b;
         hi_in   = 64'd0;
         lo_in   = is_div ? 64'd0 : mag_a;
         n_in    = {64'd0, mag_a} << FRAC_BITS;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 7'd1;
         if (div_ff) begin
            // restoring division, one quotient bit a cycle
            hi_in = ge ? rdiff[63:0] : r2[63:0];
            lo_in = {lo_ff[62:0], ge};
            n_in  = {n_ff[126:0], 1'b0};
            if (ge && !cnt_ff[6]) big_in = 1'b1;
         end else begin
            hi_in = msum[64:1];
            lo_in = {msum[0], lo_ff[63:1]};
         end
         if (last) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
   end

   always_comb begin
      prod   = {hi_ff, lo_ff};
      mag    = div_ff ? lo_ff : prod[FRAC_BITS+63:FRAC_BITS];
      big    = div_ff ? big_ff : (|prod[127:FRAC_BITS+64]);
      done   = fin_ff;
      ovf    = 1'b0;
      result = mag;
      if (neg_ff) begin
         if (big || mag > NEG_MIN) begin
            ovf    = 1'b1;
            result = NEG_MIN;
         end else begin
            result = 64'd0 - mag;
         end
      end else if (big || mag > POS_MAX) begin
         ovf    = 1'b1;
         result = POS_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
      end
      div_ff <= div_in;
      neg_ff <= neg_in;
      big_ff <= big_in;
      cnt_ff <= cnt_in;
      y_ff   <= y_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      n_ff   <= n_in;
   end

endmodule

[rtl/iee_datapath.sv]
// datapath: stacks, number accumulators, error flags and result register
`timescale 1ns / 1ps
module iee_datapath (
   input  logic              clock,
   input  logic              reset,
   input  iee_pkg::cmd_type  cmd,
   output iee_pkg::sts_type  sts,
   input  logic [7:0]        req_character,
   input  logic              req_end_marker,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic signed [63:0] rsp_value,
   output logic [2:0]        rsp_status,
   output logic              rsp_overflow
);
   import iee_pkg::*;

   logic [7:0]         char_ff, char_in;
   logic               end_ff, end_in;
   opc_type            op_stack [STACK_DEPTH];
   logic [63:0]        val_stack [STACK_DEPTH];
   opc_type            top_op_ff;
   logic [63:0]        top_val_ff;
   logic [CNT_W-1:0]   oc_ff, oc_in;
   logic [CNT_W-1:0]   vc_ff, vc_in;
   logic [31:0]        int_ff, int_in;
   logic [FR_W-1:0]    frac_ff, frac_in;
   logic [FR_W-1:0]    p10_ff, p10_in;
   logic [FDC_W-1:0]   fdc_ff, fdc_in;
   logic [1:0]         phase_ff, phase_in;
   status_type         perr_ff, perr_in;
   status_type         eval_ff, eval_in;
   logic               ovf_ff, ovf_in;
   logic               cap_ff, cap_in;
   logic               nsat_ff, nsat_in;
   opc_type            op_ff, op_in;
   logic [63:0]        a_ff, a_in;
   logic [63:0]        b_ff, b_in;
   logic               fr_busy_ff, fr_busy_in;
   logic               fr_rdy_ff, fr_rdy_in;
   logic [FCNT_W-1:0]  fr_cnt_ff, fr_cnt_in;
   logic [FR_W-1:0]    fr_r_ff, fr_r_in;
   logic [FRAC_BITS-1:0] fr_q_ff, fr_q_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_value_ff, rsp_value_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic [CNT_W-1:0]   oc_m1, vc_m1;
   logic [CNT_W-1:0]   oc_rd_addr, vc_rd_addr;
   opc_type            cur_op, op_wd;
   logic               op_we, val_we;
   logic               op_full, val_full;
   logic [3:0]         digit;
   logic [35:0]        int_next;
   logic [FR_W+3:0]    frac_next, p10_next;
   logic [FR_W:0]      fr_r2, fr_diff;
   logic               fr_ge, fr_rnd;
   logic [FRAC_BITS:0] fr_qr;
   logic [64:0]        fin_v;
   logic [64:0]        as_sum;
   logic               is_sub;
   logic               md_start, md_done, md_ovf;
   logic [63:0]        md_result;
   logic               push_en, push_ovf;
   logic [63:0]        push_val;
   status_type         out_status;

   iee_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .start  (md_start),
      .is_div (op_ff == OPC_DIV),
      .opa    (a_ff),
      .opb    (b_ff),
      .done   (md_done),
      .result (md_result),
      .ovf    (md_ovf)
   );

   always_comb begin
      oc_m1    = oc_ff - CNT_W'(1);
      vc_m1    = vc_ff - CNT_W'(1);
      op_full  = oc_ff == CNT_W'(STACK_DEPTH);
      val_full = vc_ff == CNT_W'(STACK_DEPTH);
      digit    = char_ff[3:0];
      case (char_ff)
         CH_PLUS:  cur_op = OPC_ADD;
         CH_MINUS: cur_op = OPC_SUB;
         CH_STAR:  cur_op = OPC_MUL;
         CH_SLASH: cur_op = OPC_DIV;
         default:  cur_op = OPC_NONE;
      endcase
      int_next  = {1'b0, int_ff, 3'b000} + {3'b000, int_ff, 1'b0} + {32'd0, digit};
      frac_next = {1'b0, frac_ff, 3'b000} + {3'b000, frac_ff, 1'b0} + (FR_W+4)'(digit);
      p10_next  = {1'b0, p10_ff, 3'b000} + {3'b000, p10_ff, 1'b0};

      // fraction to binary: long division by ten to the digit count
      fr_r2   = {fr_r_ff, 1'b0};
      fr_diff = fr_r2 - {1'b0, p10_ff};
      fr_ge   = fr_r2 >= {1'b0, p10_ff};
      fr_rnd  = fr_ge;
      fr_qr   = {1'b0, fr_q_ff} + (FRAC_BITS+1)'(fr_rnd);
      fin_v   = (65'(int_ff) << FRAC_BITS) + 65'(fr_qr);

      is_sub = op_ff == OPC_SUB;
      as_sum = is_sub ? ({a_ff[63], a_ff} - {b_ff[63], b_ff})
                      : ({a_ff[63], a_ff} + {b_ff[63], b_ff});

      sts.is_end       = end_ff;
      sts.halted       = cap_ff || (perr_ff != ST_OK);
      sts.is_digit     = char_ff >= CH_ZERO && char_ff <= CH_NINE;
      sts.is_dot       = char_ff == CH_DOT;
      sts.is_ws        = char_ff == CH_SPACE || (char_ff >= CH_TAB && char_ff <= CH_CR);
      sts.is_lpar      = char_ff == CH_LPAR;
      sts.is_rpar      = char_ff == CH_RPAR;
      sts.is_opchar    = cur_op != OPC_NONE;
      sts.phase_active = phase_ff != 2'd0;
      sts.op_empty     = oc_ff == '0;
      sts.top_is_lpar  = top_op_ff == OPC_LPAR;
      sts.prio_ge      = prio(top_op_ff) >= prio(cur_op);
      sts.val_lt2      = vc_ff < CNT_W'(2);
      sts.exec_long    = op_ff == OPC_MUL || (op_ff == OPC_DIV && b_ff != 64'd0);
      sts.md_done      = md_done;
      sts.fin_done     = fr_rdy_ff;
      sts.out_busy     = rsp_valid_ff && rsp_stall;

      md_start = cmd.exec_start && sts.exec_long;

      if (cap_ff) out_status = ST_STACK_FULL;
      else if (perr_ff != ST_OK) out_status = perr_ff;
      else out_status = eval_ff;
   end

   always_comb begin
      char_in    = char_ff;
      end_in     = end_ff;
      oc_in      = oc_ff;
      vc_in      = vc_ff;
      int_in     = int_ff;
      frac_in    = frac_ff;
      p10_in     = p10_ff;
      fdc_in     = fdc_ff;
      phase_in   = phase_ff;
      perr_in    = perr_ff;
      eval_in    = eval_ff;
      ovf_in     = ovf_ff;
      cap_in     = cap_ff;
      nsat_in    = nsat_ff;
      op_in      = op_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      fr_busy_in = fr_busy_ff;
      fr_rdy_in  = 1'b0;
      fr_cnt_in  = fr_cnt_ff;
      fr_r_in    = fr_r_ff;
      fr_q_in    = fr_q_ff;
      push_en    = 1'b0;
      push_val   = 64'd0;
      push_ovf   = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_ovf_in    = rsp_ovf_ff;

      if (cmd.load_item) begin
         char_in = req_character;
         end_in  = req_end_marker;
      end

      if (cmd.do_digit) begin
         unique case (phase_ff)
            2'd0: begin
               phase_in = 2'd1;
               int_in   = {28'd0, digit};
            end
            2'd1: begin
               if (int_next > 36'h0_FFFF_FFFF) begin
                  int_in  = 32'hFFFF_FFFF;
                  nsat_in = 1'b1;
               end else begin
                  int_in = int_next[31:0];
               end
            end
            2'd2: begin
               if (fdc_ff < FDC_W'(MAX_FRAC_DIGITS)) begin
                  frac_in = frac_next[FR_W-1:0];
                  p10_in  = p10_next[FR_W-1:0];
                  fdc_in  = fdc_ff + FDC_W'(1);
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.do_dot && phase_ff != 2'd3) phase_in = phase_ff + 2'd1;

      if (cmd.fin_start) begin
         fr_busy_in = 1'b1;
         fr_cnt_in  = '0;
         fr_r_in    = frac_ff;
         fr_q_in    = '0;
      end else if (fr_busy_ff) begin
         fr_r_in   = fr_ge ? fr_diff[FR_W-1:0] : fr_r2[FR_W-1:0];
         fr_q_in   = {fr_q_ff[FRAC_BITS-2:0], fr_ge};
         fr_cnt_in = fr_cnt_ff + FCNT_W'(1);
         if (fr_cnt_ff == FCNT_W'(FRAC_BITS - 1)) begin
            fr_busy_in = 1'b0;
            fr_rdy_in  = 1'b1;
         end
      end

      if (fr_rdy_ff) begin
         push_en = 1'b1;
         if (nsat_ff || 64'(int_ff) > INT_MAX || fin_v > {1'b0, POS_MAX}) begin
            push_val = POS_MAX;
            push_ovf = 1'b1;
         end else begin
            push_val = fin_v[63:0];
         end
         int_in   = 32'd0;
         frac_in  = '0;
         p10_in   = FR_W'(1);
         fdc_in   = '0;
         phase_in = 2'd0;
         nsat_in  = 1'b0;
      end

      if (cmd.push_lpar || cmd.push_cur) begin
         if (op_full) cap_in = 1'b1;
         else oc_in = oc_ff + CNT_W'(1);
      end
      if (cmd.pop_op) begin
         op_in = top_op_ff;
         oc_in = oc_m1;
      end
      if (cmd.pop_discard) oc_in = oc_m1;

      if (cmd.set_perr_char && perr_ff == ST_OK) perr_in = ST_INVALID_CHAR;
      if (cmd.set_perr_paren && perr_ff == ST_OK) perr_in = ST_PARENS;
      if (cmd.set_eval_expr && eval_ff == ST_OK) eval_in = ST_INVALID_EXPR;
      if (cmd.final_check && perr_ff == ST_OK && vc_ff != CNT_W'(1) && eval_ff == ST_OK)
         eval_in = ST_INVALID_EXPR;

      if (cmd.take_b) begin
         b_in  = top_val_ff;
         vc_in = vc_m1;
      end
      if (cmd.take_a) begin
         a_in  = top_val_ff;
         vc_in = vc_m1;
      end

      if (cmd.exec_start && !sts.exec_long) begin
         push_en = 1'b1;
         if (op_ff == OPC_DIV) begin
            push_val = 64'd0;
            if (eval_ff == ST_OK) eval_in = ST_DIV_ZERO;
         end else if (as_sum[64] != as_sum[63]) begin
            push_val = as_sum[64] ? NEG_MIN : POS_MAX;
            push_ovf = 1'b1;
         end else begin
            push_val = as_sum[63:0];
         end
      end
      if (md_done) begin
         push_en  = 1'b1;
         push_val = md_result;
         push_ovf = md_ovf;
      end

      if (push_en) begin
         if (push_ovf) ovf_in = 1'b1;
         if (val_full) cap_in = 1'b1;
         else vc_in = vc_ff + CNT_W'(1);
      end

      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = out_status;
         rsp_value_in  = (out_status == ST_OK && vc_ff != '0) ? top_val_ff : 64'd0;
         rsp_ovf_in    = ovf_ff;
         oc_in    = '0;
         vc_in    = '0;
         int_in   = 32'd0;
         frac_in  = '0;
         p10_in   = FR_W'(1);
         fdc_in   = '0;
         phase_in = 2'd0;
         perr_in  = ST_OK;
         eval_in  = ST_OK;
         ovf_in   = 1'b0;
         cap_in   = 1'b0;
         nsat_in  = 1'b0;
      end

      // stack writes and the address of the next top entry
      op_we      = (cmd.push_lpar || cmd.push_cur) && !op_full;
      op_wd      = cmd.push_lpar ? OPC_LPAR : cur_op;
      val_we     = push_en && !val_full;
      oc_rd_addr = oc_in - CNT_W'(1);
      vc_rd_addr = vc_in - CNT_W'(1);
   end

   // the top registers follow the entry below the next count; a push is its own top
   always_ff @(posedge clock) begin
      if (op_we) begin
         op_stack[oc_ff[IDX_W-1:0]] <= op_wd;
         top_op_ff <= op_wd;
      end else begin
         top_op_ff <= op_stack[oc_rd_addr[IDX_W-1:0]];
      end
      if (val_we) begin
         val_stack[vc_ff[IDX_W-1:0]] <= push_val;
         top_val_ff <= push_val;
      end else begin
         top_val_ff <= val_stack[vc_rd_addr[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oc_ff        <= '0;
         vc_ff        <= '0;
         int_ff       <= 32'd0;
         frac_ff      <= '0;
         p10_ff       <= FR_W'(1);
         fdc_ff       <= '0;
         phase_ff     <= 2'd0;
         perr_ff      <= ST_OK;
         eval_ff      <= ST_OK;
         ovf_ff       <= 1'b0;
         cap_ff       <= 1'b0;
         nsat_ff      <= 1'b0;
         fr_busy_ff   <= 1'b0;
         fr_rdy_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         oc_ff        <= oc_in;
         vc_ff        <= vc_in;
         int_ff       <= int_in;
         frac_ff      <= frac_in;
         p10_ff       <= p10_in;
         fdc_ff       <= fdc_in;
         phase_ff     <= phase_in;
         perr_ff      <= perr_in;
         eval_ff      <= eval_in;
         ovf_ff       <= ovf_in;
         cap_ff       <= cap_in;
         nsat_ff      <= nsat_in;
         fr_busy_ff   <= fr_busy_in;
         fr_rdy_ff    <= fr_rdy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      char_ff       <= char_in;
      end_ff        <= end_in;
      op_ff         <= op_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      fr_cnt_ff     <= fr_cnt_in;
      fr_r_ff       <= fr_r_in;
      fr_q_ff       <= fr_q_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_overflow = rsp_ovf_ff;

endmodule

[rtl/iee_ctrl.sv]
// controller: sequences parsing, operator stack unwinding and result transfer
`timescale 1ns / 1ps
module iee_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  iee_pkg::sts_type  sts,
   output iee_pkg::cmd_type  cmd
);
   import iee_pkg::*;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_DISPATCH;
         S_DISPATCH: begin
            if (sts.is_end) begin
               if (sts.halted) state_in = S_RESULT;
               else if (sts.phase_active) state_in = S_FIN;
               else state_in = S_FLUSH;
            end else if (sts.halted || sts.is_digit
                         || (sts.is_dot && sts.phase_active)) begin
               state_in = S_IDLE;
            end else if (sts.phase_active) begin
               state_in = S_FIN;
            end else begin
               state_in = S_CHAR;
            end
         end
         S_FIN: if (sts.fin_done) state_in = sts.is_end ? S_FLUSH : S_CHAR;
         S_CHAR: begin
            if (sts.is_rpar) state_in = S_RPAR;
            else if (sts.is_opchar) state_in = S_OPLOOP;
            else state_in = S_IDLE;
         end
         S_RPAR: begin
            if (!sts.op_empty && !sts.top_is_lpar) begin
               state_in = S_AP_B;
               ret_in   = S_RPAR;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_OPLOOP: begin
            if (!sts.op_empty && sts.prio_ge) begin
               state_in = S_AP_B;
               ret_in   = S_OPLOOP;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_FLUSH: begin
            if (sts.op_empty || sts.top_is_lpar) begin
               state_in = S_RESULT;
            end else begin
               state_in = S_AP_B;
               ret_in   = S_FLUSH;
            end
         end
         S_AP_B: state_in = sts.val_lt2 ? ret_ff : S_AP_A;
         S_AP_A: state_in = S_EXEC;
         S_EXEC: state_in = sts.exec_long ? S_WAIT : ret_ff;
         S_WAIT: if (sts.md_done) state_in = ret_ff;
         S_RESULT: if (!sts.out_busy) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = state_ff != S_IDLE;
      unique case (state_ff)
         S_IDLE: cmd.load_item = req_valid;
         S_DISPATCH: begin
            if (sts.is_end) begin
               cmd.fin_start = !sts.halted && sts.phase_active;
            end else if (!sts.halted) begin
               if (sts.is_digit) cmd.do_digit = 1'b1;
               else if (sts.is_dot && sts.phase_active) cmd.do_dot = 1'b1;
               else cmd.fin_start = sts.phase_active;
            end
         end
         S_CHAR: begin
            if (sts.is_lpar) cmd.push_lpar = 1'b1;
            else if (!sts.is_ws && !sts.is_rpar && !sts.is_opchar) cmd.set_perr_char = 1'b1;
         end
         S_RPAR: begin
            if (sts.op_empty) cmd.set_perr_paren = 1'b1;
            else if (sts.top_is_lpar) cmd.pop_discard = 1'b1;
            else cmd.pop_op = 1'b1;
         end
         S_OPLOOP: begin
            if (!sts.op_empty && sts.prio_ge) cmd.pop_op = 1'b1;
            else cmd.push_cur = 1'b1;
         end
         S_FLUSH: begin
            if (sts.op_empty) cmd.final_check = 1'b1;
            else if (sts.top_is_lpar) cmd.set_perr_paren = 1'b1;
            else cmd.pop_op = 1'b1;
         end
         S_AP_B: begin
            if (sts.val_lt2) cmd.set_eval_expr = 1'b1;
            else cmd.take_b = 1'b1;
         end
         S_AP_A: cmd.take_a = 1'b1;
         S_EXEC: cmd.exec_start = 1'b1;
         S_RESULT: cmd.emit = !sts.out_busy;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

endmodule

[tb/sv/infix_expression_evaluator_checker.sv]
// result checker: predicts each expression result from the character stream and compares
`timescale 1ns / 1ps
module infix_expression_evaluator_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [7:0]         req_character,
   input  logic               req_end_marker,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [63:0] rsp_value,
   input  logic [2:0]         rsp_status,
   input  logic               rsp_overflow,
   output int                 fail_count,
   output int                 pending_count,
   output int                 result_count
);
   import iee_pkg::*;

   localparam int EXP_DEPTH = 64;

   typedef struct packed {
      logic [63:0] value;
      status_type  status;
      logic        overflow;
   } result_type;

   result_type expected_fifo[EXP_DEPTH];
   int         exp_wr;
   int         exp_rd;

   opc_type         ops[STACK_DEPTH];
   int              op_cnt;
   logic [63:0]     vals[STACK_DEPTH];
   int              val_cnt;
   logic [31:0]     int_acc;
   longint unsigned frac_acc;
   int              frac_digits;
   int              phase;
   status_type      parse_err;
   status_type      eval_err;
   logic            ovf;
   logic            cap_err;
   logic            num_sat;

   assign pending_count = exp_wr - exp_rd;

   function automatic logic [63:0] magnitude(input logic [63:0] v);
      return v[63] ? -v : v;
   endfunction

   task automatic clear_expression();
      op_cnt = 0; val_cnt = 0; int_acc = 0; frac_acc = 0; frac_digits = 0;
      phase = 0; parse_err = ST_OK; eval_err = ST_OK; ovf = 0; cap_err = 0;
      num_sat = 0;
   endtask

   task automatic push_value(input logic [63:0] v);
      if (val_cnt >= STACK_DEPTH) cap_err = 1;
      else begin
         vals[val_cnt] = v;
         val_cnt++;
      end
   endtask

   task automatic push_op(input opc_type op);
      if (op_cnt >= STACK_DEPTH) cap_err = 1;
      else begin
         ops[op_cnt] = op;
         op_cnt++;
      end
   endtask

   task automatic saturate(input logic neg, input logic [63:0] mag, input logic big,
                           output logic [63:0] r);
      if (neg) begin
         if (big || mag > NEG_MIN) begin ovf = 1; r = NEG_MIN; end
         else r = -mag;
      end else begin
         if (big || mag > POS_MAX) begin ovf = 1; r = POS_MAX; end
         else r = mag;
      end
   endtask

   task automatic sat_add(input logic [63:0] a, input logic [63:0] b, output logic [63:0] r);
      logic [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         ovf = 1;
         r = a[63] ? NEG_MIN : POS_MAX;
      end else r = s;
   endtask

   task automatic apply_op(input opc_type op);
      logic [63:0]  a, b, v, x, y;
      logic [127:0] wide, rem, num;
      logic         big;
      if (val_cnt < 2) begin
         if (eval_err == ST_OK) eval_err = ST_INVALID_EXPR;
         return;
      end
      b = vals[val_cnt - 1];
      a = vals[val_cnt - 2];
      val_cnt -= 2;
      case (op)
         OPC_ADD: sat_add(a, b, v);
         OPC_SUB: begin
            if (b == NEG_MIN) begin
               sat_add(a, POS_MAX, v);
               sat_add(v, 64'd1, v);
            end else sat_add(a, -b, v);
         end
         OPC_MUL: begin
            x = magnitude(a); y = magnitude(b);
            wide = (128'(x) * 128'(y)) >> FRAC_BITS;
            saturate(a[63] ^ b[63], wide[63:0], wide[127:64] != 0, v);
         end
         default: begin
            if (b == 0) begin
               if (eval_err == ST_OK) eval_err = ST_DIV_ZERO;
               v = 0;
            end else begin
               x = magnitude(a); y = magnitude(b);
               num = 128'(x) << FRAC_BITS;
               wide = num / 128'(y);
               saturate(a[63] ^ b[63], wide[63:0], wide[127:64] != 0, v);
            end
         end
      endcase
      push_value(v);
   endtask

   task automatic close_number();
      longint unsigned p, r, q;
      logic [63:0] v;
      if (phase == 0) return;
      p = 1;
      for (int k = 0; k < frac_digits; k++) p = p * 10;
      r = frac_acc; q = 0;
      for (int k = 0; k < FRAC_BITS; k++) begin
         r = r << 1; q = q << 1;
         if (r >= p) begin r = r - p; q = q | 1; end
      end
      if ((r << 1) >= p) q = q + 1;
      if (num_sat || 64'(int_acc) > INT_MAX) begin
         ovf = 1; v = POS_MAX;
      end else begin
         v = (64'(int_acc) << FRAC_BITS) + q;
         if (v > POS_MAX) begin ovf = 1; v = POS_MAX; end
      end
      push_value(v);
      int_acc = 0; frac_acc = 0; frac_digits = 0; phase = 0; num_sat = 0;
   endtask

   task automatic take_character(input logic [7:0] c);
      opc_type         op;
      longint unsigned n;
      if (cap_err || parse_err != ST_OK) return;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         if (phase == 0) begin
            phase = 1; int_acc = 32'(c - CH_ZERO);
         end else if (phase == 1) begin
            n = longint'(int_acc) * 10 + (c - CH_ZERO);
            if (n > 64'hFFFF_FFFF) begin n = 64'hFFFF_FFFF; num_sat = 1; end
            int_acc = n[31:0];
         end else if (phase == 2 && frac_digits < MAX_FRAC_DIGITS) begin
            frac_acc = frac_acc * 10 + (c - CH_ZERO);
            frac_digits++;
         end
         return;
      end
      if (c == CH_DOT && phase != 0) begin
         if (phase < 3) phase++;
         return;
      end
      close_number();
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return;
      if (c == CH_LPAR) begin push_op(OPC_LPAR); return; end
      if (c == CH_RPAR) begin
         while (op_cnt > 0 && ops[op_cnt - 1] != OPC_LPAR) begin
            op_cnt--;
            apply_op(ops[op_cnt]);
         end
         if (op_cnt == 0) begin
            if (parse_err == ST_OK) parse_err = ST_PARENS;
         end else op_cnt--;
         return;
      end
      case (c)
         CH_PLUS:  op = OPC_ADD;
         CH_MINUS: op = OPC_SUB;
         CH_STAR:  op = OPC_MUL;
         CH_SLASH: op = OPC_DIV;
         default:  op = OPC_NONE;
      endcase
      if (op == OPC_NONE) begin
         if (parse_err == ST_OK) parse_err = ST_INVALID_CHAR;
         return;
      end
      while (op_cnt > 0 && prio(ops[op_cnt - 1]) >= prio(op)) begin
         op_cnt--;
         apply_op(ops[op_cnt]);
      end
      push_op(op);
   endtask

   task automatic finish_expression();
      result_type res;
      if (!cap_err && parse_err == ST_OK) begin
         close_number();
         while (op_cnt > 0) begin
            if (ops[op_cnt - 1] == OPC_LPAR) begin
               parse_err = ST_PARENS;
               break;
            end
            op_cnt--;
            apply_op(ops[op_cnt]);
         end
         if (parse_err == ST_OK && val_cnt != 1 && eval_err == ST_OK)
            eval_err = ST_INVALID_EXPR;
      end
      res.status = cap_err ? ST_STACK_FULL : (parse_err != ST_OK ? parse_err : eval_err);
      res.value = (res.status == ST_OK && val_cnt > 0) ? vals[0] : 64'd0;
      res.overflow = ovf;
      expected_fifo[exp_wr % EXP_DEPTH] = res;
      exp_wr++;
      clear_expression();
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      result_count = 0;
      clear_expression();
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (req_end_marker) finish_expression();
            else take_character(req_character);
         end
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (exp_wr == exp_rd)
               report_mismatch("unexpected result", rsp_value, 64'd0);
            else begin
               want = expected_fifo[exp_rd % EXP_DEPTH];
               exp_rd++;
               if (rsp_value !== want.value) report_mismatch("value", rsp_value, want.value);
               if (rsp_status !== want.status)
                  report_mismatch("status", 64'(rsp_status), 64'(want.status));
               if (rsp_overflow !== want.overflow)
                  report_mismatch("overflow", 64'(rsp_overflow), 64'(want.overflow));
            end
         end
      end
   end
endmodule

[tb/sv/infix_expression_evaluator_tb.sv]
// testbench top: character stimulus, random stalls and the verdict
`timescale 1ns / 1ps
module infix_expression_evaluator_tb;
   import iee_pkg::*;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [7:0]         req_character;
   logic               req_end_marker;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [63:0] rsp_value;
   logic [2:0]         rsp_status;
   logic               rsp_overflow;
   int                 fail_count;
   int                 pending_count;
   int                 result_count;
   int                 char_count;
   int                 expr_count;
   logic               stall_quiet;

   infix_expression_evaluator dut (.*);

   infix_expression_evaluator_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // one transfer, then an optional idle gap
   task automatic send(input logic [7:0] c, input logic is_end);
      int gap;
      req_valid <= 1;
      req_character <= c;
      req_end_marker <= is_end;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (is_end) expr_count++;
      else char_count++;
      gap = stall_quiet ? 0 : gap_length();
      if (gap > 0) begin
         req_valid <= 0;
         req_character <= 8'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_text(input string s);
      for (int k = 0; k < s.len(); k++) send(s[k], 0);
      send(8'($urandom), 1);
   endtask

   function automatic string random_number();
      string s;
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) s = "4294967299";
      else if (r == 1) s = "0";
      else s = $sformatf("%0d", $urandom_range(0, r < 5 ? 9 : 99999));
      if ($urandom_range(0, 2) == 0) begin
         s = {s, "."};
         repeat ($urandom_range(0, 12)) s = {s, string'(8'($urandom_range(CH_ZERO, CH_NINE)))};
         if ($urandom_range(0, 6) == 0) s = {s, ".5"};
      end
      return s;
   endfunction

   function automatic string random_op();
      case ($urandom_range(0, 3))
         0: return "+";
         1: return "-";
         2: return "*";
         default: return "/";
      endcase
   endfunction

   function automatic string random_expr(input int depth);
      string s;
      int terms;
      terms = $urandom_range(1, 3);
      s = "";
      for (int k = 0; k < terms; k++) begin
         if (k > 0) s = {s, random_op()};
         if ($urandom_range(0, 5) == 0) s = {s, " "};
         if (depth > 0 && $urandom_range(0, 3) == 0)
            s = {s, "(", random_expr(depth - 1), ")"};
         else s = {s, random_number()};
      end
      return s;
   endfunction

   // random stall on the result side
   initial begin
      int n;
      rsp_stall = 0;
      @(negedge reset);
      forever begin
         n = gap_length();
         if (stall_quiet) n = 0;
         rsp_stall <= n > 0;
         @(posedge clock);
         if (n > 1) repeat (n - 1) @(posedge clock);
         rsp_stall <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   initial begin
      #60ms;
      $display("infix_expression_evaluator_tb: FAIL");
      $finish;
   end

   initial begin
      string s;
      int wait_cycles;
      reset = 1;
      req_valid = 0;
      req_character = 0;
      req_end_marker = 0;
      char_count = 0;
      expr_count = 0;
      stall_quiet = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_text("1+2");
      send_text("7-10");
      send_text("3*4.5");
      send_text("7/2");
      send_text("2+3*4-(6/3)");
      send_text("1/0");
      send_text("");
      send_text("(1+2");
      send_text("1+2)");
      send_text("1 # 2");
      send_text(".5");
      send_text("1.2.3+4");
      send_text("0.1234567891234");
      send_text("99999999999");
      send_text("2147483647*2147483647");
      send_text("1+");
      send_text("1 2");
      send_text("\t1\n+\r2 ");
      s = "";
      repeat (33) s = {s, "("};
      send_text(s);
      s = "1";
      repeat (33) s = {s, "+(1"};
      send_text(s);

      stall_quiet = 1;
      for (int k = 0; k < 6; k++) send_text(random_expr(1));
      stall_quiet = 0;

      while (char_count + expr_count < 1870) begin
         case ($urandom_range(0, 9))
            0: begin
               // raw noise, every byte value possible
               s = "";
               repeat ($urandom_range(1, 6)) s = {s, string'(8'($urandom_range(1, 255)))};
               send(8'($urandom), 0);
               send_text(s);
            end
            1: begin
               // broken sequence
               s = random_expr(2);
               s = s.substr(0, $urandom_range(0, s.len() - 1));
               send_text(s);
            end
            default: send_text(random_expr(2));
         endcase
      end

      req_valid <= 0;
      wait_cycles = 0;
      while (pending_count != 0 && wait_cycles < 200000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (300) @(posedge clock);
      $display("covered %0d characters in %0d expressions, %0d results checked",
               char_count, expr_count, result_count);
      if (fail_count == 0 && pending_count == 0)
         $display("infix_expression_evaluator_tb: PASS");
      else
         $display("infix_expression_evaluator_tb: FAIL");
      $finish;
   end
endmodule

[filelist.f]
+incdir+rtl
rtl/iee_pkg.sv
rtl/iee_muldiv.sv
rtl/iee_datapath.sv
rtl/iee_ctrl.sv
rtl/infix_expression_evaluator.sv
tb/sv/infix_expression_evaluator_checker.sv
tb/sv/infix_expression_evaluator_tb.sv
